>>> rtl/core/smpq_pkg.sv
// Shared types and codes for the stable max-priority queue.
// No dependencies; used by smpq_cell and stable_max_priority_queue_top.
package smpq_pkg;

	localparam int KEY_W    = 16;
	localparam int TAG_W    = 16;
	localparam int OUTKEY_W = 17;
	localparam int OCC_W    = 8;

	// Operation codes on the operation port
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Key reported when no entry leaves the queue (-1)
	localparam logic signed [OUTKEY_W-1:0] KEY_NONE = '1;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_FULL   = 2'd1,
		ST_POPPED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} cell_cmd_t;

endpackage

>>> rtl/core/smpq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward the tail on insert
// and toward the head on removal. Depends on smpq_pkg.
module smpq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic                clk,
	input  smpq_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0]       count,
	input  smpq_pkg::entry_t    left_ent,
	input  logic                left_ins,
	input  smpq_pkg::entry_t    right_ent,
	output smpq_pkg::entry_t    ent,
	output logic                ins
);

	smpq_pkg::entry_t ent_q;
	logic             occupied;

	assign occupied = count > CW'(IDX);
	// Strict compare keeps equal keys ahead of the newcomer
	assign ins      = !occupied || (ent_q.key < cmd.ent.key);
	assign ent      = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.push && ins) begin
			ent_q <= left_ins ? left_ent : cmd.ent;
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

>>> rtl/core/stable_max_priority_queue_top.sv
// Top level of the stable max-priority queue: controller, counter and cell chain.
// Depends on smpq_pkg and smpq_cell.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   command  | start / busy        | operation, key, tag
//   result   | done (one cycle)    | status, out_key, out_tag, occupancy
//
// A transaction is accepted at a clock edge with start high and busy low. Every
// cell updates at that same edge, so push and pop both finish regardless of
// occupancy; the result stands on the outputs in the next cycle with done high,
// and busy is high during that cycle, so no new transaction is accepted while a
// result is shown. The receiver cannot stall: a result is shown exactly once.
// Reset empties the queue at once (the counter clears); cell contents stay as
// they were and are never read before being written again.
module stable_max_priority_queue_top #(
	parameter int CAPACITY = 128
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	output logic                                         busy,
	input  logic                                         operation,
	input  logic [smpq_pkg::KEY_W-1:0]                   key,
	input  logic [smpq_pkg::TAG_W-1:0]                   tag,
	output logic                                         done,
	output logic [1:0]                                   status,
	output logic signed [smpq_pkg::OUTKEY_W-1:0]         out_key,
	output logic [smpq_pkg::TAG_W-1:0]                   out_tag,
	output logic [smpq_pkg::OCC_W-1:0]                   occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                                 accept;
	logic                                 full;
	logic                                 empty;
	logic [CW-1:0]                        count_q;
	logic [CW-1:0]                        count_nxt;
	smpq_pkg::cell_cmd_t                  cmd;
	smpq_pkg::entry_t                     cell_ent [CAPACITY];
	logic                                 cell_ins [CAPACITY];

	logic                                 done_q;
	smpq_pkg::status_t                    status_q;
	logic signed [smpq_pkg::OUTKEY_W-1:0] out_key_q;
	logic [smpq_pkg::TAG_W-1:0]           out_tag_q;

	assign accept = start && !busy;
	assign full   = count_q == CW'(CAPACITY);
	assign empty  = count_q == '0;

	// Broadcast the command; drop a push when full and a pop when empty
	assign cmd.push    = accept && (operation == smpq_pkg::OP_PUSH) && !full;
	assign cmd.pop     = accept && (operation == smpq_pkg::OP_POP) && !empty;
	assign cmd.ent.key = key;
	assign cmd.ent.tag = tag;

	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// Chain kept sorted by descending key, ties in arrival order; the head is the max
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smpq_pkg::entry_t left_ent;
		logic             left_ins;
		smpq_pkg::entry_t right_ent;

		if (i == 0) begin : g_head
			assign left_ent = cmd.ent;
			assign left_ins = 1'b0;
		end else begin : g_body
			assign left_ent = cell_ent[i-1];
			assign left_ins = cell_ins[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_mid
			assign right_ent = cell_ent[i+1];
		end

		smpq_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count_q),
			.left_ent (left_ent),
			.left_ins (left_ins),
			.right_ent(right_ent),
			.ent      (cell_ent[i]),
			.ins      (cell_ins[i])
		);
	end

	// Counter and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// Result payload: capture the head before it shifts out
	always_ff @(posedge clk) begin
		if (accept) begin
			out_key_q <= smpq_pkg::KEY_NONE;
			out_tag_q <= '0;
			if (operation == smpq_pkg::OP_PUSH) begin
				status_q <= full ? smpq_pkg::ST_FULL : smpq_pkg::ST_PUSHED;
			end else if (empty) begin
				status_q <= smpq_pkg::ST_EMPTY;
			end else begin
				status_q  <= smpq_pkg::ST_POPPED;
				out_key_q <= {1'b0, cell_ent[0].key};
				out_tag_q <= cell_ent[0].tag;
			end
		end
	end

	assign busy      = done_q;
	assign done      = done_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign occupancy = smpq_pkg::OCC_W'(count_q);

	// Every accepted transaction produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted transaction produced no result");

	// Counter stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// Head and second cell stay in descending key order
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_ent[0].key >= cell_ent[1].key))
		else $error("cell chain out of order at head");

	// A pop on empty reports no entry and an empty queue
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == smpq_pkg::ST_EMPTY) |->
			(occupancy == '0 && out_key == smpq_pkg::KEY_NONE && out_tag == '0))
		else $error("pop on empty reported an entry");

endmodule
